/* rtl/channel_command_stream_parser_core_defines.svh */
// Assertion macros shared by the command stream parser RTL.
`ifndef CHANNEL_COMMAND_STREAM_PARSER_CORE_DEFINES_SVH
`define CHANNEL_COMMAND_STREAM_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CCSP_ASSERT_NOW(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ccsp assertion failed");

// Next-cycle implication, checked outside reset.
`define CCSP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ccsp assertion failed");

`endif

/* rtl/ccsp_pkg.sv */
// Package with opcodes, result codes, types and helpers of the command stream parser.
`timescale 1ns / 1ps

package ccsp_pkg;

	localparam logic [3:0] OPC_SET_CLASS = 4'd0;
	localparam logic [3:0] OPC_INCR      = 4'd1;
	localparam logic [3:0] OPC_NONINCR   = 4'd2;
	localparam logic [3:0] OPC_MASK      = 4'd3;
	localparam logic [3:0] OPC_IMM       = 4'd4;

	localparam logic KIND_WRITE       = 1'b0;
	localparam logic KIND_UNSUPPORTED = 1'b1;

	typedef logic [31:0] word_t;
	typedef logic [9:0]  class_t;
	typedef logic [11:0] offset_t;
	typedef logic [15:0] slot_mask_t;
	typedef logic [15:0] count_t;

	typedef struct packed {
		logic    kind;
		class_t  unit_class;
		offset_t method_index;
		word_t   payload;
	} result_t;

	// Index of the lowest set bit, zero when no bit is set.
	function automatic logic [3:0] lowest_set(input slot_mask_t m);
		logic [3:0] idx;
		idx = 4'd0;
		for (int i = 15; i >= 0; i--) begin
			if (m[i]) begin
				idx = 4'(i);
			end
		end
		return idx;
	endfunction

endpackage

/* rtl/ccsp_word_if.sv */
// Channel carrying raw command stream words.
`timescale 1ns / 1ps

interface ccsp_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

/* rtl/ccsp_result_if.sv */
// Channel carrying parser results (method writes and unsupported reports).
`timescale 1ns / 1ps

interface ccsp_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [9:0]  unit_class;
	logic [11:0] method_index;
	logic [31:0] payload;

	modport source (output valid, output kind, output unit_class, output method_index,
		output payload, input ready);
	modport sink (input valid, input kind, input unit_class, input method_index,
		input payload, output ready);
endinterface

/* rtl/channel_command_stream_parser_core.sv */
// Top level of the channel command stream parser: word decode, method state, result register.
//
//   channel | dir | fields                                       | handshake
//   --------+-----+----------------------------------------------+------------
//   cmd     | in  | word[31:0]                                   | valid/ready
//   res     | out | kind, unit_class[9:0], method_index[11:0],   | valid/ready
//           |     | payload[31:0]                                |
//
// One item per cycle sustained unless a result is blocked; an accepted word passes through the
// input register, then decode and state update, into the result register.
// The decode step reads and writes the method state in the same cycle, so words that
// follow each other back to back see the state left by the word before.
// arst_n clears the pending mask, count, base, increment flag, class and valid bits.
// A stalled result only holds words that produce a result; words that only load state
// keep flowing. cmd.ready falls only while the input register is full and blocked.
`timescale 1ns / 1ps
`include "channel_command_stream_parser_core_defines.svh"

module channel_command_stream_parser_core (
	input logic           clk,
	input logic           arst_n,
	ccsp_word_if.sink     cmd,
	ccsp_result_if.source res
);
	import ccsp_pkg::*;

	// Input register
	logic  valid_s1;
	word_t word_s1;

	// Method state
	slot_mask_t pend_mask_q;
	count_t     pend_cnt_q;
	offset_t    base_q;
	logic       auto_inc_q;
	class_t     class_q;

	// Result register
	logic    res_valid_q;
	result_t res_q;

	// Decode signals
	logic       [3:0] opc;
	offset_t    off;
	logic       [15:0] val;
	logic       mask_nz;
	logic       cnt_nz;
	logic       [3:0] slot;
	logic       emit;
	logic       adv;
	result_t    res_d;
	slot_mask_t pend_mask_d;
	count_t     pend_cnt_d;
	offset_t    base_d;
	logic       auto_inc_d;
	class_t     class_d;

	assign opc     = word_s1[31:28];
	assign off     = word_s1[27:16];
	assign val     = word_s1[15:0];
	assign mask_nz = |pend_mask_q;
	assign cnt_nz  = |pend_cnt_q;
	assign slot    = lowest_set(pend_mask_q);

	// Decode the held word against the current method state
	always_comb begin
		pend_mask_d = pend_mask_q;
		pend_cnt_d  = pend_cnt_q;
		base_d      = base_q;
		auto_inc_d  = auto_inc_q;
		class_d     = class_q;
		emit        = 1'b0;
		res_d.kind         = KIND_WRITE;
		res_d.unit_class   = class_q;
		res_d.method_index = base_q;
		res_d.payload      = word_s1;
		if (mask_nz) begin
			// Masked payload: write to base plus lowest pending slot, drop that slot
			pend_mask_d = pend_mask_q & ~(slot_mask_t'(1) << slot);
			res_d.method_index = base_q + offset_t'(slot);
			emit = 1'b1;
		end else if (cnt_nz) begin
			// Counted payload: write to base, advance base when incrementing
			pend_cnt_d = pend_cnt_q - count_t'(1);
			if (auto_inc_q) begin
				base_d = base_q + offset_t'(1);
			end
			emit = 1'b1;
		end else begin
			case (opc)
				OPC_SET_CLASS: begin
					pend_mask_d = {10'b0, val[5:0]};
					base_d      = off;
					class_d     = val[15:6];
				end
				OPC_INCR, OPC_NONINCR: begin
					pend_cnt_d = val;
					base_d     = off;
					auto_inc_d = (opc == OPC_INCR);
				end
				OPC_MASK: begin
					pend_mask_d = val;
					base_d      = off;
				end
				OPC_IMM: begin
					base_d = off;
					res_d.method_index = off;
					res_d.payload      = {20'b0, val[11:0]};
					emit = 1'b1;
				end
				default: begin
					res_d.kind         = KIND_UNSUPPORTED;
					res_d.method_index = '0;
					res_d.payload      = '0;
					emit = 1'b1;
				end
			endcase
		end
	end

	// Advance unless a result is due and the result register is blocked
	assign adv       = valid_s1 && (!emit || !res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || adv;

	// Hold the incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			word_s1 <= cmd.word;
		end
	end

	// Update method state as each word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_mask_q <= '0;
			pend_cnt_q  <= '0;
			base_q      <= '0;
			auto_inc_q  <= 1'b0;
			class_q     <= '0;
		end else if (adv) begin
			pend_mask_q <= pend_mask_d;
			pend_cnt_q  <= pend_cnt_d;
			base_q      <= base_d;
			auto_inc_q  <= auto_inc_d;
			class_q     <= class_d;
		end
	end

	// Load or drain the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= res_d;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.kind         = res_q.kind;
	assign res.unit_class   = res_q.unit_class;
	assign res.method_index = res_q.method_index;
	assign res.payload      = res_q.payload;

	// A masked payload word retires exactly one pending slot
	`CCSP_ASSERT_NEXT(a_mask_drops_one, clk, arst_n, adv && mask_nz,
		($countones(pend_mask_q) + 1) == $countones($past(pend_mask_q)))
	// A counted payload word lowers the count by one
	`CCSP_ASSERT_NEXT(a_count_drops_one, clk, arst_n, adv && !mask_nz && cnt_nz,
		pend_cnt_q == ($past(pend_cnt_q) - count_t'(1)))
	// Every payload word yields a result
	`CCSP_ASSERT_NEXT(a_payload_emits, clk, arst_n, adv && (mask_nz || cnt_nz), res_valid_q)
	// An unsupported report carries no write
	`CCSP_ASSERT_NOW(a_unsupported_empty, clk, arst_n,
		res_valid_q && (res_q.kind == KIND_UNSUPPORTED),
		(res_q.method_index == '0) && (res_q.payload == '0))

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench of the channel command stream parser: directed and random word streams.
`timescale 1ns / 1ps

module testbench;
	import ccsp_pkg::*;

	localparam int HALF_PERIOD     = 2;
	localparam int RESET_CYCLES    = 10;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 10;
	localparam int MAX_REPORTS     = 30;
	localparam int PHASE_WORDS     = 440;
	localparam int BURST_WORDS     = 40;

	// Header opcodes beyond the supported set.
	localparam logic [3:0] OPC_FIRST_UNSUPPORTED = 4'd5;
	localparam logic [3:0] OPC_LAST_UNSUPPORTED  = 4'd15;

	logic clk = 1'b0;
	logic arst_n;

	ccsp_word_if   cmd_ch();
	ccsp_result_if res_ch();

	channel_command_stream_parser_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	// Parser state as the predictor tracks it.
	slot_mask_t slot_bits;
	count_t     words_left;
	offset_t    cur_base;
	logic       step_base;
	class_t     cur_class;

	result_t due_results[$];

	int errors        = 0;
	int words_sent    = 0;
	int send_idle_pct = 25;
	int recv_idle_pct = 78;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	always #(HALF_PERIOD) clk = ~clk;

	// Decode one word against the tracked state; return 1 when it yields a result.
	function automatic bit decode_word(input word_t w, output result_t r);
		logic [3:0]  opc;
		offset_t     off;
		logic [15:0] val;
		int          slot;
		opc = w[31:28];
		off = w[27:16];
		val = w[15:0];
		r = '0;
		r.unit_class = cur_class;
		// mask payload goes to the lowest pending slot
		if (slot_bits != '0) begin
			slot = 0;
			while (!slot_bits[slot]) begin
				slot++;
			end
			slot_bits[slot] = 1'b0;
			r.kind = KIND_WRITE;
			r.method_index = cur_base + offset_t'(slot);
			r.payload = w;
			return 1'b1;
		end
		// counted payload goes to the base, which may step
		if (words_left != '0) begin
			r.kind = KIND_WRITE;
			r.method_index = cur_base;
			r.payload = w;
			words_left = words_left - count_t'(1);
			if (step_base) begin
				cur_base = cur_base + offset_t'(1);
			end
			return 1'b1;
		end
		case (opc)
			OPC_SET_CLASS: begin
				slot_bits = {10'd0, val[5:0]};
				cur_class = val[15:6];
				cur_base = off;
				return 1'b0;
			end
			OPC_INCR, OPC_NONINCR: begin
				words_left = val;
				cur_base = off;
				step_base = (opc == OPC_INCR);
				return 1'b0;
			end
			OPC_MASK: begin
				slot_bits = val;
				cur_base = off;
				return 1'b0;
			end
			OPC_IMM: begin
				cur_base = off;
				r.kind = KIND_WRITE;
				r.method_index = off;
				r.payload = {20'd0, val[11:0]};
				return 1'b1;
			end
			default: begin
				r.kind = KIND_UNSUPPORTED;
				return 1'b1;
			end
		endcase
	endfunction

	// Offer one item from a falling edge until accepted; return at the next falling edge.
	task automatic send_word(input word_t w);
		result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.word  <= $urandom;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.word  <= w;
		do begin
			@(posedge clk);
		end while (cmd_ch.ready !== 1'b1);
		if (decode_word(w, r)) begin
			due_results.push_back(r);
		end
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_payloads(input int n);
		repeat (n) begin
			send_word($urandom);
		end
	endtask

	task automatic flag_field(input string field, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= MAX_REPORTS) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			end
		end
	endtask

	// Field extremes, every supported opcode, unsupported opcodes at both range ends and the empty headers.
	task automatic test_directed();
		// immediate at both offset extremes; value bits above 11 drop
		send_word({OPC_IMM, 12'hfff, 16'hffff});
		send_word({OPC_IMM, 12'h000, 16'h0000});
		// top class with slots 0 and 5; the second slot wraps the offset
		send_word({OPC_SET_CLASS, 12'hffe, 10'h3ff, 6'h21});
		send_word(32'hffff_ffff);
		send_word(32'h0000_0000);
		// incrementing count wraps the base; payloads that look like headers
		send_word({OPC_INCR, 12'hffe, 16'd3});
		send_word({OPC_IMM, 12'hfff, 16'hffff});
		send_word({OPC_LAST_UNSUPPORTED, 28'h0});
		send_word($urandom);
		// non-incrementing count holds the base
		send_word({OPC_NONINCR, 12'h123, 16'd2});
		send_payloads(2);
		// sparse mask at both ends of the slot range
		send_word({OPC_MASK, 12'hff0, 16'h8001});
		send_payloads(2);
		// empty headers: the next word decodes as a header again
		send_word({OPC_MASK, 12'h456, 16'h0000});
		send_word({OPC_INCR, 12'h789, 16'h0000});
		send_word({OPC_NONINCR, 12'habc, 16'h0000});
		// unsupported opcodes at both ends of the range
		send_word({OPC_FIRST_UNSUPPORTED, 28'h0});
		send_word({OPC_LAST_UNSUPPORTED, 28'hfff_ffff});
	endtask

	// Mostly well-formed header and payload runs, with some noise words.
	task automatic test_random(input int s_pct, input int r_pct);
		int    stop_at;
		int    pick;
		int    n;
		word_t w;
		send_idle_pct = s_pct;
		recv_idle_pct <= r_pct;
		stop_at = words_sent + PHASE_WORDS;
		while (words_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				w = {OPC_SET_CLASS, 12'($urandom), 16'($urandom)};
				send_word(w);
				send_payloads($countones(w[5:0]));
			end else if (pick < 35) begin
				n = ($urandom_range(49) == 0) ? $urandom_range(300, 64) : $urandom_range(6);
				w = {($urandom_range(1) ? OPC_INCR : OPC_NONINCR), 12'($urandom), 16'(n)};
				send_word(w);
				send_payloads(n);
			end else if (pick < 55) begin
				w = {OPC_MASK, 12'($urandom), 16'($urandom)};
				send_word(w);
				send_payloads($countones(w[15:0]));
			end else if (pick < 80) begin
				send_word({OPC_IMM, 28'($urandom)});
			end else if (pick < 90) begin
				send_word({4'($urandom_range(OPC_LAST_UNSUPPORTED, OPC_FIRST_UNSUPPORTED)),
					28'($urandom)});
			end else begin
				// noise: any word, may open or break a run
				send_word($urandom);
			end
		end
	endtask

	// Hold the result side off while immediates keep coming, so the input stalls.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		hold_requests <= hold_requests + 1;
		repeat (BURST_WORDS) begin
			send_word({OPC_IMM, 28'($urandom)});
		end
	endtask

	// Drive result ready: random idling, or a long hold when requested.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: unexpected result, expected none, actual %0h %0h %0h %0h",
						$time, res_ch.kind, res_ch.unit_class, res_ch.method_index,
						res_ch.payload);
				end
			end else begin
				want = due_results.pop_front();
				flag_field("kind", 32'(want.kind), 32'(res_ch.kind));
				flag_field("unit_class", 32'(want.unit_class), 32'(res_ch.unit_class));
				flag_field("method_index", 32'(want.method_index),
					32'(res_ch.method_index));
				flag_field("payload", want.payload, res_ch.payload);
			end
		end
	end

	// End the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
			(res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("channel_command_stream_parser_core regression: fail");
			$finish;
		end
	end

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.word  = '0;
		arst_n       = 1'b0;
		slot_bits    = '0;
		words_left   = '0;
		cur_base     = '0;
		step_base    = 1'b0;
		cur_class    = '0;
		repeat (RESET_CYCLES) begin
			@(negedge clk);
		end
		arst_n = 1'b1;

		test_directed();
		test_random(25, 78);
		test_random(78, 25);
		test_random(0, 0);
		test_backpressure();
		cmd_ch.valid <= 1'b0;

		// drain, then allow for the pipeline latency
		while (due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) begin
			@(posedge clk);
		end
		if (errors == 0 && due_results.size() == 0) begin
			$display("channel_command_stream_parser_core regression: pass");
		end else begin
			$display("channel_command_stream_parser_core regression: fail");
		end
		$finish;
	end

endmodule
